/* hdl/ahfe_pkg.sv */
package ahfe_pkg;

    localparam int MAX_PAYLOAD_DEF = 249;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_ADDRESS = 2'd1;
    localparam logic [1:0] REG_DEVTYPE = 2'd2;

    localparam logic [7:0] VERSION_RST = 8'h20;
    localparam logic [7:0] ADDRESS_RST = 8'h01;
    localparam logic [7:0] DEVTYPE_RST = 8'h41;

    localparam logic [7:0] SOI_CHAR = 8'h7E;
    localparam logic [7:0] EOI_CHAR = 8'h0D;
    localparam logic [7:0] ERR_CHAR = 8'h00;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        close;
        logic [7:0]  data;
        logic [15:0] len_word;
    } cmd_t;

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        logic [7:0] v;
        v = {4'h0, n};
        return (n < 4'd10) ? v + 8'h30 : v + 8'h37;
    endfunction

    function automatic logic [15:0] len_word(input logic [7:0] plen);
        logic [11:0] lenid;
        logic [3:0]  s;
        lenid = {3'b000, plen, 1'b0};
        s = lenid[11:8] + lenid[7:4] + lenid[3:0];
        return {4'h0 - s, lenid};
    endfunction

endpackage

/* hdl/ahfe_front.sv */
module ahfe_front #(
    parameter int MAX_PAYLOAD = ahfe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           op,
    input  logic [7:0]     command_code,
    input  logic [7:0]     payload_length,
    input  logic [7:0]     payload_byte,
    input  logic           q_full,
    output logic           push,
    output ahfe_pkg::cmd_t push_cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        bytes_left_next   = bytes_left_reg;
        push              = 1'b0;
        push_cmd.kind     = ahfe_pkg::KIND_ERR;
        push_cmd.close    = 1'b0;
        push_cmd.data     = payload_byte;
        push_cmd.len_word = ahfe_pkg::len_word(payload_length);
        if (accept)
        begin
            if (op == ahfe_pkg::OP_START)
            begin
                push = 1'b1;
                if (payload_length > 8'(MAX_PAYLOAD))
                begin
                    push_cmd.kind = ahfe_pkg::KIND_ERR;
                end
                else
                begin
                    push_cmd.kind   = ahfe_pkg::KIND_START;
                    push_cmd.data   = command_code;
                    push_cmd.close  = (payload_length == 8'd0);
                    in_frame_next   = (payload_length != 8'd0);
                    bytes_left_next = payload_length;
                end
            end
            else if (in_frame_reg)
            begin
                push            = 1'b1;
                push_cmd.kind   = ahfe_pkg::KIND_BYTE;
                push_cmd.close  = (bytes_left_reg == 8'd1);
                bytes_left_next = bytes_left_reg - 8'd1;
                in_frame_next   = (bytes_left_reg != 8'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

/* hdl/ahfe_queue.sv */
module ahfe_queue #(
    parameter int DEPTH = ahfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ahfe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ahfe_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ahfe_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/ahfe_back.sv */
module ahfe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ahfe_pkg::cmd_t q_cmd,
    output logic           q_pop,
    input  logic [7:0]     protocol_version,
    input  logic [7:0]     station_address,
    input  logic [7:0]     device_type,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_char,
    output logic           last,
    output logic           length_error
);

    localparam logic [1:0] PH_SOI = 2'd0;
    localparam logic [1:0] PH_HEX = 2'd1;
    localparam logic [1:0] PH_TRL = 2'd2;
    localparam logic [1:0] PH_ERR = 2'd3;

    localparam logic [2:0] HDR_LAST_IDX = 3'd5;
    localparam logic [2:0] TRL_EOI_IDX  = 3'd4;

    logic           busy_reg;
    logic           busy_next;
    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [2:0]     idx_reg;
    logic [2:0]     idx_next;
    logic           half_reg;
    logic           half_next;
    logic [15:0]    sum_reg;
    logic [15:0]    sum_next;
    ahfe_pkg::cmd_t cur_reg;
    ahfe_pkg::cmd_t cur_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_char_reg;
    logic [7:0]     out_char_next;
    logic           out_last_reg;
    logic           out_last_next;
    logic           out_err_reg;
    logic           out_err_next;

    ahfe_pkg::cmd_t cur;
    logic [1:0]     ph;
    logic [2:0]     i;
    logic           h;
    logic           active;
    logic           advance;
    logic [7:0]     hex_byte;
    logic [7:0]     hex_char;
    logic [15:0]    chk;
    logic [7:0]     trl_char;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last         = out_last_reg;
    assign length_error = out_err_reg;

    assign cur     = busy_reg ? cur_reg : q_cmd;
    assign active  = busy_reg || q_valid;
    assign advance = active && (!out_valid_reg || !out_stall);
    assign q_pop   = advance && !busy_reg;
    assign chk     = 16'h0000 - sum_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            ph = phase_reg;
            i  = idx_reg;
            h  = half_reg;
        end
        else
        begin
            i = 3'd0;
            h = 1'b0;
            case (cur.kind)
                ahfe_pkg::KIND_START: ph = PH_SOI;
                ahfe_pkg::KIND_BYTE:  ph = PH_HEX;
                default:              ph = PH_ERR;
            endcase
        end
    end

    always_comb
    begin
        if (cur.kind == ahfe_pkg::KIND_BYTE)
        begin
            hex_byte = cur.data;
        end
        else
        begin
            case (i)
                3'd0:    hex_byte = protocol_version;
                3'd1:    hex_byte = station_address;
                3'd2:    hex_byte = device_type;
                3'd3:    hex_byte = cur.data;
                3'd4:    hex_byte = cur.len_word[15:8];
                default: hex_byte = cur.len_word[7:0];
            endcase
        end
        hex_char = ahfe_pkg::nib_char(h ? hex_byte[3:0] : hex_byte[7:4]);
        case (i)
            3'd0:    trl_char = ahfe_pkg::nib_char(chk[15:12]);
            3'd1:    trl_char = ahfe_pkg::nib_char(chk[11:8]);
            3'd2:    trl_char = ahfe_pkg::nib_char(chk[7:4]);
            3'd3:    trl_char = ahfe_pkg::nib_char(chk[3:0]);
            default: trl_char = ahfe_pkg::EOI_CHAR;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        half_next      = half_reg;
        sum_next       = sum_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (advance)
        begin
            cur_next       = cur;
            busy_next      = 1'b1;
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_err_next   = 1'b0;
            case (ph)
                PH_SOI:
                begin
                    out_char_next = ahfe_pkg::SOI_CHAR;
                    sum_next      = 16'h0000;
                    phase_next    = PH_HEX;
                    idx_next      = 3'd0;
                    half_next     = 1'b0;
                end
                PH_HEX:
                begin
                    out_char_next = hex_char;
                    sum_next      = sum_reg + {8'h00, hex_char};
                    phase_next    = PH_HEX;
                    idx_next      = i;
                    half_next     = 1'b0;
                    if (!h)
                    begin
                        half_next = 1'b1;
                    end
                    else if (cur.kind == ahfe_pkg::KIND_START && i != HDR_LAST_IDX)
                    begin
                        idx_next = i + 3'd1;
                    end
                    else if (cur.close)
                    begin
                        phase_next = PH_TRL;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        out_last_next = 1'b1;
                        busy_next     = 1'b0;
                    end
                end
                PH_TRL:
                begin
                    out_char_next = trl_char;
                    phase_next    = PH_TRL;
                    if (i == TRL_EOI_IDX)
                    begin
                        out_last_next = 1'b1;
                        busy_next     = 1'b0;
                    end
                    else
                    begin
                        idx_next = i + 3'd1;
                    end
                end
                default:
                begin
                    out_char_next = ahfe_pkg::ERR_CHAR;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b1;
                    busy_next     = 1'b0;
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_SOI;
            idx_reg       <= 3'd0;
            half_reg      <= 1'b0;
            sum_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            half_reg      <= half_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && out_char_reg == ahfe_pkg::ERR_CHAR))
        else $error("length error transaction is not a single zero character");

    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_reg != PH_ERR))
        else $error("sequencer busy in error phase");

    a_eoi_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ph == PH_TRL && i == TRL_EOI_IDX) |=>
            (!busy_reg && out_last_reg && out_char_reg == ahfe_pkg::EOI_CHAR))
        else $error("frame did not close on EOI");

endmodule

/* hdl/ascii_hex_frame_encoder_core.sv */
// ASCII-hex frame encoder. A start transaction (op 0) produces SOI, twelve
// hex characters of header and, for an empty payload, four checksum
// characters and EOI; each payload transaction (op 1) produces two hex
// characters, plus checksum and EOI after the final byte. A start with a
// length above MAX_PAYLOAD produces one character 0 flagged length_error.
// The back end emits one character per cycle while out_stall is low and
// commands are waiting; the front end accepts a transaction every cycle
// while its QUEUE_DEPTH-entry command queue has room. Version, address
// and device type sit in APB registers at 0x0, 0x4 and 0x8.
module ascii_hex_frame_encoder_core #(
    parameter int MAX_PAYLOAD = ahfe_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = ahfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ahfe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ahfe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ahfe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [7:0]                      command_code,
    input  logic [7:0]                      payload_length,
    input  logic [7:0]                      payload_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_char,
    output logic                            last,
    output logic                            length_error
);

    logic [7:0]     version_reg;
    logic [7:0]     address_reg;
    logic [7:0]     devtype_reg;
    logic           cfg_write;
    logic [7:0]     rd_byte;

    logic           push;
    ahfe_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    ahfe_pkg::cmd_t q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            ahfe_pkg::REG_VERSION: rd_byte = version_reg;
            ahfe_pkg::REG_ADDRESS: rd_byte = address_reg;
            ahfe_pkg::REG_DEVTYPE: rd_byte = devtype_reg;
            default:               rd_byte = 8'h00;
        endcase
        prdata = {{(ahfe_pkg::CFG_DATA_W - 8){1'b0}}, rd_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= ahfe_pkg::VERSION_RST;
            address_reg <= ahfe_pkg::ADDRESS_RST;
            devtype_reg <= ahfe_pkg::DEVTYPE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                ahfe_pkg::REG_VERSION: version_reg <= pwdata[7:0];
                ahfe_pkg::REG_ADDRESS: address_reg <= pwdata[7:0];
                ahfe_pkg::REG_DEVTYPE: devtype_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    ahfe_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .command_code  (command_code),
        .payload_length(payload_length),
        .payload_byte  (payload_byte),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    ahfe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    ahfe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_head),
        .q_pop           (q_pop),
        .protocol_version(version_reg),
        .station_address (address_reg),
        .device_type     (devtype_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_char        (out_char),
        .last            (last),
        .length_error    (length_error)
    );

endmodule

/* dv/tb_ascii_hex_frame_encoder_core.sv */
module tb_ascii_hex_frame_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_LEN = ahfe_pkg::MAX_PAYLOAD_DEF;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_SILENT = 2'd1;
    localparam logic [1:0] ROW_TYPED = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] cmd;
        logic [7:0] plen;
        logic [7:0] pbyte;
    } enc_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       err;
    } frame_char_t;

    typedef struct packed {
        enc_item_t  item;
        logic [1:0] mode;
        logic [7:0] t_char;
        logic       t_err;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ahfe_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ahfe_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ahfe_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_stall;
    logic                            op;
    logic [7:0]                      command_code;
    logic [7:0]                      payload_length;
    logic [7:0]                      payload_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic [7:0]                      out_char;
    logic                            last;
    logic                            length_error;

    ascii_hex_frame_encoder_core uut (.*);

    // encoder shadow state
    logic [7:0]  cfg_regs [0:2];
    logic [7:0]  bytes_left;
    logic [15:0] frame_sum;
    logic        in_frame;
    logic [7:0]  held_char;
    bit          has_held;

    frame_char_t expected_chars [$];

    bit quiet_mode;
    int fail_count;
    int items_sent;
    int chars_checked;
    int frames_closed;

    stim_row_t stim_rows [0:18] = '{
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'hFF, ROW_SILENT,  ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h00, 8'd0,   8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'hFF, 8'd250, 8'h00, ROW_TYPED,   ahfe_pkg::ERR_CHAR, 1'b1},
        {ahfe_pkg::OP_START, 8'h5A, 8'd255, 8'hFF, ROW_TYPED,   ahfe_pkg::ERR_CHAR, 1'b1},
        {ahfe_pkg::OP_START, 8'hA5, 8'd249, 8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'hFF, 8'hFF,  8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'h00,  8'hFF, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h42, 8'd1,   8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'h9C, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'h11, ROW_SILENT,  ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h01, 8'd2,   8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'hA0, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h33, 8'd250, 8'h00, ROW_TYPED,   ahfe_pkg::ERR_CHAR, 1'b1},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'h0F, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h80, 8'd128, 8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_START, 8'h7F, 8'd3,   8'h00, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'h55, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'hAA, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0},
        {ahfe_pkg::OP_BYTE,  8'h00, 8'd0,   8'h3C, ROW_PREDICT, ahfe_pkg::ERR_CHAR, 1'b0}
    };

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n > 4'd9)
            return 8'h37 + {4'h0, n};
        return 8'h30 + {4'h0, n};
    endfunction

    // the newest character is held back so the final one of a transaction gets last
    function automatic void emit(input logic [7:0] c, input bit counted);
        if (has_held)
            expected_chars.push_back({held_char, 1'b0, 1'b0});
        held_char = c;
        has_held = 1'b1;
        if (counted)
            frame_sum = frame_sum + {8'h00, c};
    endfunction

    function automatic void emit_hex(input logic [7:0] b);
        emit(hex_digit(b[7:4]), 1'b1);
        emit(hex_digit(b[3:0]), 1'b1);
    endfunction

    function automatic void close_frame();
        logic [15:0] chk;
        chk = 16'h0000 - frame_sum;
        emit(hex_digit(chk[15:12]), 1'b0);
        emit(hex_digit(chk[11:8]), 1'b0);
        emit(hex_digit(chk[7:4]), 1'b0);
        emit(hex_digit(chk[3:0]), 1'b0);
        emit(ahfe_pkg::EOI_CHAR, 1'b0);
        in_frame = 1'b0;
        bytes_left = 8'h00;
        frames_closed++;
    endfunction

    function automatic void encode_step(input enc_item_t it);
        logic [11:0] lenid;
        logic [3:0]  lchk;
        if (it.op == ahfe_pkg::OP_START)
        begin
            if (int'(it.plen) > MAX_LEN)
            begin
                expected_chars.push_back({ahfe_pkg::ERR_CHAR, 1'b1, 1'b1});
                return;
            end
            frame_sum = 16'h0000;
            emit(ahfe_pkg::SOI_CHAR, 1'b0);
            emit_hex(cfg_regs[ahfe_pkg::REG_VERSION]);
            emit_hex(cfg_regs[ahfe_pkg::REG_ADDRESS]);
            emit_hex(cfg_regs[ahfe_pkg::REG_DEVTYPE]);
            emit_hex(it.cmd);
            lenid = {3'b000, it.plen, 1'b0};
            lchk = 4'h0 - lenid[11:8] - lenid[7:4] - lenid[3:0];
            emit_hex({lchk, lenid[11:8]});
            emit_hex(lenid[7:0]);
            if (it.plen == 8'h00)
                close_frame();
            else
            begin
                in_frame = 1'b1;
                bytes_left = it.plen;
            end
        end
        else
        begin
            if (!in_frame)
                return;
            emit_hex(it.pbyte);
            bytes_left = bytes_left - 8'h01;
            if (bytes_left == 8'h00)
                close_frame();
        end
        expected_chars.push_back({held_char, 1'b1, 1'b0});
        has_held = 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 4);
        if (r < 90)
            return $urandom_range(5, 16);
        return $urandom_range(17, 40);
    endfunction

    function automatic enc_item_t rand_item(input logic op_v);
        enc_item_t it;
        it.op = op_v;
        it.cmd = 8'($urandom());
        it.plen = 8'($urandom());
        it.pbyte = 8'($urandom());
        return it;
    endfunction

    // called at a rising edge; returns at the edge the transaction is taken
    task automatic send_item(input enc_item_t it, input bit modeled);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        command_code <= it.cmd;
        payload_length <= it.plen;
        payload_byte <= it.pbyte;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        if (modeled)
            encode_step(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] rd;
        logic [1:0]  ri;
        apb_xfer(1'b1, idx, {24'($urandom()), val}, rd);
        if (idx != REG_UNUSED)
            cfg_regs[idx] = val;
        for (int i = 0; i < 3; i++)
        begin
            ri = 2'(i);
            apb_xfer(1'b0, ri, 32'h0, rd);
            if (rd !== {24'h0, cfg_regs[ri]})
            begin
                $display("%0t: reg %0d readback expected %h got %h",
                         $time, ri, {24'h0, cfg_regs[ri]}, rd);
                fail_count++;
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // mostly complete frames, plus truncated frames, rejected starts and stray bytes
    task automatic run_random(input int target);
        int stop_at;
        int kind;
        int n;
        enc_item_t it;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            it = rand_item(ahfe_pkg::OP_START);
            if (kind < 7)
            begin
                n = pick_len();
                it.plen = n[7:0];
                send_item(it, 1'b1);
                repeat (n) send_item(rand_item(ahfe_pkg::OP_BYTE), 1'b1);
            end
            else if (kind == 7)
            begin
                it.plen = 8'($urandom_range(2, 12));
                send_item(it, 1'b1);
                repeat ($urandom_range(0, it.plen - 1))
                    send_item(rand_item(ahfe_pkg::OP_BYTE), 1'b1);
            end
            else if (kind == 8)
            begin
                it.plen = 8'($urandom_range(MAX_LEN + 1, 255));
                send_item(it, 1'b1);
            end
            else
                send_item(rand_item(ahfe_pkg::OP_BYTE), 1'b1);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d characters still expected", $time, expected_chars.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : char_sink
        frame_char_t want;
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected transaction char %h last %b err %b",
                             $time, out_char, last, length_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (out_char !== want.ch)
                    begin
                        $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $display("%0t: last expected %b got %b", $time, want.fin, last);
                        fail_count++;
                    end
                    if (length_error !== want.err)
                    begin
                        $display("%0t: length_error expected %b got %b",
                                 $time, want.err, length_error);
                        fail_count++;
                    end
                end
            end
            if (hold > 0)
                hold--;
            else if (quiet_mode || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 5);
            end
            else
            begin
                out_stall <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial
    begin : main
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        op <= ahfe_pkg::OP_START;
        command_code <= 8'h00;
        payload_length <= 8'h00;
        payload_byte <= 8'h00;
        cfg_regs[ahfe_pkg::REG_VERSION] = ahfe_pkg::VERSION_RST;
        cfg_regs[ahfe_pkg::REG_ADDRESS] = ahfe_pkg::ADDRESS_RST;
        cfg_regs[ahfe_pkg::REG_DEVTYPE] = ahfe_pkg::DEVTYPE_RST;
        bytes_left = 8'h00;
        frame_sum = 16'h0000;
        in_frame = 1'b0;
        has_held = 1'b0;
        quiet_mode = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            send_item(stim_rows[i].item, stim_rows[i].mode == ROW_PREDICT);
            if (stim_rows[i].mode == ROW_TYPED)
                expected_chars.push_back({stim_rows[i].t_char, 1'b1, stim_rows[i].t_err});
        end
        drain();

        write_reg(REG_UNUSED, 8'h5A);
        write_reg(ahfe_pkg::REG_VERSION, 8'hFF);
        write_reg(ahfe_pkg::REG_ADDRESS, 8'hFF);
        write_reg(ahfe_pkg::REG_DEVTYPE, 8'hFF);
        run_random(30);
        drain();

        write_reg(ahfe_pkg::REG_VERSION, 8'h00);
        write_reg(ahfe_pkg::REG_ADDRESS, 8'h00);
        write_reg(ahfe_pkg::REG_DEVTYPE, 8'h00);
        run_random(30);
        drain();

        write_reg(ahfe_pkg::REG_VERSION, 8'($urandom()));
        write_reg(ahfe_pkg::REG_ADDRESS, 8'($urandom()));
        write_reg(ahfe_pkg::REG_DEVTYPE, 8'($urandom()));
        run_random(35);
        drain();

        $display("Ran %0d input transactions and checked %0d output characters, %0d frames closed,",
                 items_sent, chars_checked, frames_closed);
        $display("under reset, all-ones, all-zeros and random header registers.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* ascii_hex_frame_encoder_core.f */
hdl/ahfe_pkg.sv
hdl/ahfe_front.sv
hdl/ahfe_queue.sv
hdl/ahfe_back.sv
hdl/ascii_hex_frame_encoder_core.sv
dv/tb_ascii_hex_frame_encoder_core.sv
